// ===== design/gppe_pkg.sv =====
`timescale 1ns / 1ps
package gppe_pkg;

	localparam int unsigned COORD_W   = 16;
	localparam int unsigned PAYLOAD_W = 40;
	localparam int unsigned SEQ_W     = 32;
	localparam int unsigned ADDR_W    = 35;
	localparam int unsigned DIST_W    = 34;
	localparam int unsigned SQ_W      = 32;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 34;

	localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DIST = 1'd1;

	localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

	localparam logic [PAYLOAD_W-1:0] FLAG_START = 40'h80_0000_0000;
	localparam logic [PAYLOAD_W-1:0] FLAG_JUMP  = 40'h40_0000_0000;
	localparam logic [PAYLOAD_W-1:0] FLAG_END   = 40'h20_0000_0000;

	localparam logic [DIST_W-1:0] NEAR_DIST_RESET = 34'd100;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] end_payload;
		logic [PAYLOAD_W-1:0] payload;
		logic                 pre_end;
		logic                 start_rep;
		logic                 post_end;
	} gppe_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_POINT,
		ST_REP,
		ST_POST
	} gppe_step_t;

	function automatic logic [PAYLOAD_W-1:0] end_of(input logic [PAYLOAD_W-1:0] p);
		end_of = (p & ~(FLAG_START | FLAG_JUMP)) | FLAG_END;
	endfunction

endpackage

// ===== design/gppe_front.sv =====
`timescale 1ns / 1ps
module gppe_front
	import gppe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  near_load,
	input  logic [DIST_W-1:0]     near_value,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_W-1:0]    in_x,
	input  logic [COORD_W-1:0]    in_y,
	input  logic                  in_path_first,
	input  logic                  in_path_last,
	input  logic                  in_drawing_last,
	output logic                  q_push,
	output gppe_cmd_t             q_data,
	input  logic                  q_full
);

	logic [DIST_W-1:0]    near_q;
	logic                 have_prev_q;
	logic                 awaiting_q;
	logic [COORD_W-1:0]   prev_x_q;
	logic [COORD_W-1:0]   prev_y_q;
	logic [PAYLOAD_W-1:0] prev_payload_q;

	logic                 v_s1;
	logic [COORD_W-1:0]   x_s1;
	logic [COORD_W-1:0]   y_s1;
	logic                 pf_s1;
	logic                 pl_s1;
	logic                 dl_s1;

	logic                 v_s2;
	logic [COORD_W-1:0]   x_s2;
	logic [COORD_W-1:0]   y_s2;
	logic                 pf_s2;
	logic                 pl_s2;
	logic                 dl_s2;
	logic                 eq_s2;
	logic [SQ_W-1:0]      dxsq_s2;
	logic [SQ_W-1:0]      dysq_s2;

	logic [COORD_W-1:0]   dx;
	logic [COORD_W-1:0]   dy;
	logic                 accept;
	logic                 adv1;
	logic                 fire2;
	logic                 dup;
	logic                 first_in;
	logic                 first_eff;
	logic                 near_pt;
	logic                 pre_end;
	logic                 near_hit;
	logic [SQ_W:0]        dist_sum;
	logic [PAYLOAD_W-1:0] payload;

	assign dx = (x_s1 >= prev_x_q) ? (x_s1 - prev_x_q) : (prev_x_q - x_s1);
	assign dy = (y_s1 >= prev_y_q) ? (y_s1 - prev_y_q) : (prev_y_q - y_s1);

	assign dup      = have_prev_q && eq_s2;
	assign fire2    = v_s2 && (dup || !q_full);
	assign q_push   = v_s2 && !dup && !q_full;
	assign adv1     = v_s1 && (!v_s2 || fire2);
	assign in_ready = !v_s1 && (!v_s2 || fire2);
	assign accept   = in_valid && in_ready;

	assign dist_sum = {1'b0, dxsq_s2} + {1'b0, dysq_s2};
	assign near_hit = DIST_W'(dist_sum) <= near_q;
	assign first_in = awaiting_q || pf_s2;

	always_comb begin
		first_eff = first_in;
		near_pt   = 1'b0;
		pre_end   = 1'b0;
		if (have_prev_q) begin
			if (!first_in) begin
				near_pt = near_hit;
			end else if (near_hit) begin
				first_eff = 1'b0;
			end else begin
				pre_end = 1'b1;
			end
		end
		payload = (PAYLOAD_W'(x_s2) << 1) | (PAYLOAD_W'(y_s2) << 21);
		if (first_eff) begin
			payload = payload | FLAG_START;
		end else if (!near_pt) begin
			payload = payload | FLAG_JUMP;
		end
	end

	assign q_data.end_payload = end_of(prev_payload_q);
	assign q_data.payload     = payload;
	assign q_data.pre_end     = pre_end;
	assign q_data.start_rep   = first_eff;
	assign q_data.post_end    = dl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q         <= NEAR_DIST_RESET;
			have_prev_q    <= 1'b0;
			awaiting_q     <= 1'b1;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			prev_payload_q <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
		end else begin
			if (near_load) begin
				near_q <= near_value;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (fire2) begin
				v_s2 <= 1'b0;
			end
			if (fire2) begin
				awaiting_q  <= pl_s2;
				have_prev_q <= have_prev_q | pl_s2;
				if (!dup) begin
					prev_x_q       <= x_s2;
					prev_y_q       <= y_s2;
					prev_payload_q <= payload;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= in_x;
			y_s1  <= in_y;
			pf_s1 <= in_path_first;
			pl_s1 <= in_path_last;
			dl_s1 <= in_drawing_last;
		end
		if (adv1) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			pf_s2   <= pf_s1;
			pl_s2   <= pl_s1;
			dl_s2   <= dl_s1;
			eq_s2   <= (x_s1 == prev_x_q) && (y_s1 == prev_y_q);
			dxsq_s2 <= SQ_W'(dx) * SQ_W'(dx);
			dysq_s2 <= SQ_W'(dy) * SQ_W'(dy);
		end
	end

endmodule

// ===== design/gppe_fifo.sv =====
`timescale 1ns / 1ps
module gppe_fifo
	import gppe_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  gppe_cmd_t wr_data,
	output logic      full,
	input  logic      pop,
	output gppe_cmd_t rd_data,
	output logic      empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	gppe_cmd_t          mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");

endmodule

// ===== design/gppe_back.sv =====
`timescale 1ns / 1ps
module gppe_back
	import gppe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seq_load,
	input  logic [SEQ_W-1:0]     seq_value,
	input  gppe_cmd_t            q_data,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_W-1:0]    out_word_address,
	output logic [PAYLOAD_W-1:0] out_payload,
	output logic [KIND_W-1:0]    out_record_kind,
	output logic                 out_last
);

	gppe_step_t           state_q;
	gppe_step_t           state_d;
	gppe_cmd_t            cur_q;
	logic [SEQ_W-1:0]     seq_q;
	logic                 ov_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [KIND_W-1:0]    kind_q;
	logic                 last_q;

	logic [PAYLOAD_W-1:0] rec_payload;
	logic [KIND_W-1:0]    rec_kind;
	logic                 rec_final;
	logic                 load;
	gppe_step_t           entry_step;
	gppe_step_t           after_step;

	always_comb begin
		rec_payload = '0;
		rec_kind    = KIND_POINT;
		rec_final   = 1'b0;
		case (state_q)
			ST_PRE: begin
				rec_payload = cur_q.end_payload;
				rec_kind    = KIND_END;
			end
			ST_POINT: begin
				rec_payload = cur_q.payload;
				rec_kind    = KIND_POINT;
				rec_final   = !cur_q.start_rep && !cur_q.post_end;
			end
			ST_REP: begin
				rec_payload = cur_q.payload & ~FLAG_START;
				rec_kind    = KIND_REPEAT;
				rec_final   = !cur_q.post_end;
			end
			ST_POST: begin
				rec_payload = end_of(cur_q.payload);
				rec_kind    = KIND_END;
				rec_final   = 1'b1;
			end
			default: begin
				rec_payload = '0;
			end
		endcase
	end

	assign load       = (state_q != ST_IDLE) && (!ov_q || out_ready);
	assign q_pop      = ((state_q == ST_IDLE) || (load && rec_final)) && !q_empty;
	assign entry_step = q_data.pre_end ? ST_PRE : ST_POINT;
	assign after_step = q_pop ? entry_step : ST_IDLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_pop) state_d = entry_step;
			end
			ST_PRE: begin
				if (load) state_d = ST_POINT;
			end
			ST_POINT: begin
				if (load) begin
					if (cur_q.start_rep) state_d = ST_REP;
					else if (cur_q.post_end) state_d = ST_POST;
					else state_d = after_step;
				end
			end
			ST_REP: begin
				if (load) state_d = cur_q.post_end ? ST_POST : after_step;
			end
			ST_POST: begin
				if (load) state_d = after_step;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seq_load) begin
				seq_q <= seq_value;
			end else if (load) begin
				seq_q <= seq_q + 1'b1;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (load) begin
			addr_q    <= {seq_q, 3'b000};
			payload_q <= rec_payload;
			kind_q    <= rec_kind;
			last_q    <= rec_final;
		end
	end

	assign out_valid        = ov_q;
	assign out_word_address = addr_q;
	assign out_payload      = payload_q;
	assign out_record_kind  = kind_q;
	assign out_last         = last_q;

	a_seq_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !seq_load) |=> (seq_q == $past(seq_q) + 1'b1))
		else $error("sequence did not advance by one record");

	a_pre_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRE) |-> cur_q.pre_end)
		else $error("join end record without a far join");

	a_rep_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REP) |-> cur_q.start_rep)
		else $error("start repeat without a start point");

endmodule

// ===== design/galvo_path_point_encoder.sv =====
`timescale 1ns / 1ps
// Galvo path point encoder.
// Slave stream: one path point per transaction. tdata = x[15:0], y[31:16];
// tlast = path_last; tuser[0] = path_first, tuser[1] = drawing_last.
// Master stream: one marking record per transaction. tdata = word_address
// [34:0], payload [74:35], zero pad [79:75]; tuser = record_kind; tlast is
// set on the final record caused by a point.
// Configuration: cfg_we with cfg_index 0 loads start_sequence (and the
// record counter), index 1 loads near_distance_sq. Write only while idle.
// A point passes a two-stage classifier (distance squares, then compare and
// flag decisions), is queued, and a record sequencer emits its records.
// Throughput: the classifier takes no new point while its first stage holds
// one; the sequencer sends one record per cycle while the receiver is ready,
// 1 to 4 records per point. A duplicate point emits nothing.
// Reset clears the queue and the path state, sets the counter to 0 and the
// near distance to 100. When the receiver stalls, the output register
// holds its record, the queue fills, and then tready drops.
module galvo_path_point_encoder
	import gppe_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // x, y
	input  logic                  s_axis_tlast,
	input  logic [1:0]            s_axis_tuser,  // path_first, drawing_last
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [79:0]           m_axis_tdata,  // word_address, payload, pad
	output logic                  m_axis_tlast,
	output logic [KIND_W-1:0]     m_axis_tuser   // record_kind
);

	gppe_cmd_t            push_data;
	gppe_cmd_t            pop_data;
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	logic [ADDR_W-1:0]    word_address;
	logic [PAYLOAD_W-1:0] payload;

	gppe_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.near_load       (cfg_we && (cfg_index == CFG_NEAR_DIST)),
		.near_value      (cfg_wdata[DIST_W-1:0]),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_x            (s_axis_tdata[15:0]),
		.in_y            (s_axis_tdata[31:16]),
		.in_path_first   (s_axis_tuser[0]),
		.in_path_last    (s_axis_tlast),
		.in_drawing_last (s_axis_tuser[1]),
		.q_push          (push),
		.q_data          (push_data),
		.q_full          (full)
	);

	gppe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.full    (full),
		.pop     (pop),
		.rd_data (pop_data),
		.empty   (empty)
	);

	gppe_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.seq_load         (cfg_we && (cfg_index == CFG_START_SEQ)),
		.seq_value        (cfg_wdata[SEQ_W-1:0]),
		.q_data           (pop_data),
		.q_empty          (empty),
		.q_pop            (pop),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_word_address (word_address),
		.out_payload      (payload),
		.out_record_kind  (m_axis_tuser),
		.out_last         (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b00000, payload, word_address};

endmodule
